// ===== rtl/hlmmi_pkg.sv =====
// Package for the hub-label max-min intersection block.
// Holds the list depth, entry layout, action codes, sequencer states and control structs.
// No dependencies.
package hlmmi_pkg;

  // list depth and derived widths
  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int HUB_W       = 20;
  localparam int OV_W        = 16;
  localparam int ACT_W       = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_APPEND_FIRST  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND_SECOND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY         = 2'd2;

  // one label entry
  typedef struct packed {
    logic [HUB_W-1:0] hub;
    logic [OV_W-1:0]  ov;
  } entry_t;

  // per-list memory control
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
  } mem_ctl_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic             walking;
    logic [CNT_W-1:0] cnt_first;
    logic [CNT_W-1:0] cnt_second;
  } seq_stat_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_COMPARE,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/hlmmi_list_store.sv =====
// Label list memory: one write port and one registered read port.
// Depends on hlmmi_pkg for the entry layout and depth.
module hlmmi_list_store
  import hlmmi_pkg::*;
(
  input  logic     clk,
  input  mem_ctl_t ctl,
  input  entry_t   wdata,
  output entry_t   rdata
);

  entry_t mem [MAX_ENTRIES];

  // write port
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[ctl.raddr];
  end

endmodule

// ===== rtl/hlmmi_seq.sv =====
// Sequencer and shared compare unit for the merge walk, with list counts and result register.
// Depends on hlmmi_pkg; drives the two hlmmi_list_store instances.
module hlmmi_seq
  import hlmmi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [HUB_W-1:0]  hub_id,
  input  logic [OV_W-1:0]   overlap,
  input  logic [OV_W-1:0]   start_overlap,
  output mem_ctl_t          ctl_first,
  output mem_ctl_t          ctl_second,
  output entry_t            wdata,
  input  entry_t            rd_first,
  input  entry_t            rd_second,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OV_W-1:0]   best_overlap,
  output logic              hit,
  output seq_stat_t         stat
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt_a, cnt_b;
  logic [CNT_W-1:0] idx_a, idx_b;
  logic [OV_W-1:0]  best, start;
  logic             hit_run;
  logic             walk_more;
  logic             in_xfer;
  logic             load_res;
  logic             room_a, room_b;
  logic [OV_W-1:0]  ov_min;

  assign walk_more = (idx_a < cnt_a) && (idx_b < cnt_b);
  assign in_xfer   = in_valid && in_ready;
  assign room_a    = cnt_a < CNT_W'(MAX_ENTRIES);
  assign room_b    = cnt_b < CNT_W'(MAX_ENTRIES);
  assign ov_min    = (rd_first.ov < rd_second.ov) ? rd_first.ov : rd_second.ov;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && action == ACT_QUERY) state_next = ST_FETCH;
      end
      ST_FETCH: begin
        state_next = walk_more ? ST_COMPARE : ST_FINISH;
      end
      ST_COMPARE: begin
        state_next = ST_FETCH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state-dependent outputs
  always_comb begin
    in_ready = 1'b0;
    load_res = 1'b0;
    unique case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_FETCH:   in_ready = 1'b0;
      ST_COMPARE: in_ready = 1'b0;
      ST_FINISH:  load_res = !out_valid || out_ready;
      default:    in_ready = 1'b0;
    endcase
  end

  // memory control: appends write at the fill count, the walk reads at the indexes
  always_comb begin
    ctl_first.we     = in_xfer && action == ACT_APPEND_FIRST && room_a;
    ctl_first.waddr  = cnt_a[IDX_W-1:0];
    ctl_first.raddr  = idx_a[IDX_W-1:0];
    ctl_second.we    = in_xfer && action == ACT_APPEND_SECOND && room_b;
    ctl_second.waddr = cnt_b[IDX_W-1:0];
    ctl_second.raddr = idx_b[IDX_W-1:0];
    wdata.hub        = hub_id;
    wdata.ov         = overlap;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // list counts
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (load_res) begin
      cnt_a <= '0;
      cnt_b <= '0;
    end else begin
      if (ctl_first.we)  cnt_a <= cnt_a + CNT_W'(1);
      if (ctl_second.we) cnt_b <= cnt_b + CNT_W'(1);
    end
  end

  // walk indexes and running values, one compare per step
  always_ff @(posedge clk) begin
    if (in_xfer && action == ACT_QUERY) begin
      idx_a   <= '0;
      idx_b   <= '0;
      best    <= start_overlap;
      start   <= start_overlap;
      hit_run <= 1'b0;
    end else if (state == ST_COMPARE) begin
      if (rd_first.hub > rd_second.hub) begin
        idx_b <= idx_b + CNT_W'(1);
      end else if (rd_first.hub < rd_second.hub) begin
        idx_a <= idx_a + CNT_W'(1);
      end else begin
        if (rd_first.ov >= start && rd_second.ov >= start) hit_run <= 1'b1;
        if (rd_first.ov > best && rd_second.ov > best) best <= ov_min;
        idx_a <= idx_a + CNT_W'(1);
        idx_b <= idx_b + CNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_res) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      best_overlap <= best;
      hit          <= hit_run;
    end
  end

  assign stat.walking    = (state != ST_IDLE);
  assign stat.cnt_first  = cnt_a;
  assign stat.cnt_second = cnt_b;

endmodule

// ===== rtl/hub_label_max_min_intersection_core.sv =====
// Top level of the hub-label max-min intersection block.
// Depends on hlmmi_pkg, hlmmi_list_store and hlmmi_seq.

// Appends (action 0 or 1) are accepted back to back while the block is idle;
// appends past the list depth are dropped and action 3 is ignored.
// A query (action 2) merge-walks both lists through one registered read port per list
// and a single compare unit: each step is a fetch state and a compare state, and one
// last fetch and a finish state close the walk; the number of steps is at most
// first_count + second_count. Input is ready again in the same cycle as the result
// appears. The finish state also waits while an earlier result still sits untaken in
// the output register. The block holds ready low for the whole walk. Appends for the
// next query are taken while a result waits; both lists are emptied when the result
// is produced.
module hub_label_max_min_intersection_core
  import hlmmi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ACT_W-1:0]  action,
  input  logic [HUB_W-1:0]  hub_id,
  input  logic [OV_W-1:0]   overlap,
  input  logic [OV_W-1:0]   start_overlap,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [OV_W-1:0]   best_overlap,
  output logic              hit
);

  mem_ctl_t  ctl_first, ctl_second;
  entry_t    wdata, rd_first, rd_second;
  seq_stat_t stat;

  // label list memories
  hlmmi_list_store u_first (
    .clk   (clk),
    .ctl   (ctl_first),
    .wdata (wdata),
    .rdata (rd_first)
  );

  hlmmi_list_store u_second (
    .clk   (clk),
    .ctl   (ctl_second),
    .wdata (wdata),
    .rdata (rd_second)
  );

  // sequencer and compare unit
  hlmmi_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .hub_id        (hub_id),
    .overlap       (overlap),
    .start_overlap (start_overlap),
    .ctl_first     (ctl_first),
    .ctl_second    (ctl_second),
    .wdata         (wdata),
    .rd_first      (rd_first),
    .rd_second     (rd_second),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .best_overlap  (best_overlap),
    .hit           (hit),
    .stat          (stat)
  );

`ifndef ASSERT_OFF
  // a query transfer starts a walk
  a_query_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_QUERY) |=> stat.walking)
    else $error("query transfer did not start a walk");

  // no input transfer during a walk
  a_no_accept_walking: assert property (@(posedge clk) disable iff (rst)
    stat.walking |-> !in_ready)
    else $error("input ready during a walk");

  // fill counts stay within the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (stat.cnt_first <= CNT_W'(MAX_ENTRIES)) && (stat.cnt_second <= CNT_W'(MAX_ENTRIES)))
    else $error("list count beyond depth");

  // a fresh result comes only with emptied lists
  a_result_clears: assert property (@(posedge clk) disable iff (rst)
    (!out_valid ##1 out_valid) |-> (stat.cnt_first == '0 && stat.cnt_second == '0))
    else $error("lists not cleared with result");
`endif

endmodule
